>>> design/two_way_data_cache_lrf_assert.svh
// Assertion macros used by the checker file of the data cache.
`ifndef TWO_WAY_DATA_CACHE_LRF_ASSERT_SVH
`define TWO_WAY_DATA_CACHE_LRF_ASSERT_SVH

// Same-cycle implication under reset.
`define TWDC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("data cache check failed");

// Next-cycle implication under reset.
`define TWDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("data cache check failed");

`endif

>>> design/twdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdc_pkg
// Shared constants, codes and controller/datapath link types of the cache.
// ----------------------------------------------------------------------------
package twdc_pkg;

  // Geometry
  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned NUM_SETS      = 64;
  localparam int unsigned LINE_DEPTH    = 1024;
  localparam int unsigned LINE_OFF_BITS = 6;
  localparam int unsigned FLAG_BITS     = 12;

  // Tag flag bit positions
  localparam int unsigned DIRTY_BIT = 6;
  localparam int unsigned VALID_BIT = 5;
  localparam int unsigned LRF_BIT   = 4;

  // Sweep counter ends
  localparam logic [3:0] SWEEP_LAST = 4'd8;
  localparam logic [3:0] DROP_LAST  = 4'd7;

  // Access sizes
  localparam logic [2:0] LSZ_HALF  = 3'd1;
  localparam logic [2:0] LSZ_BYTE  = 3'd0;
  localparam logic [2:0] LSZ_WORD  = 3'd2;
  localparam logic [2:0] LSZ_QUAD  = 3'd4;

  // Request types
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_CACHE = 2'd2;

  // Maintenance operation codes
  localparam logic [3:0] OP_DHIN   = 4'd0;
  localparam logic [3:0] OP_DHWBIN = 4'd1;
  localparam logic [3:0] OP_DHWOIN = 4'd2;
  localparam logic [3:0] OP_DXIN   = 4'd3;
  localparam logic [3:0] OP_DXLDT  = 4'd4;
  localparam logic [3:0] OP_DXLTG  = 4'd5;
  localparam logic [3:0] OP_DXSDT  = 4'd6;
  localparam logic [3:0] OP_DXSTG  = 4'd7;
  localparam logic [3:0] OP_DXWBIN = 4'd8;

  typedef enum logic [2:0] {
    K_NONE,
    K_READ,
    K_WRITE,
    K_HITOP,
    K_INDEX
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic clear_run;
    logic capture;
    logic lookup;
    logic cnt_run;
    logic wb;
    logic fill;
    logic drop;
    logic rd0;
    logic rd1;
    logic rd2;
    logic wr0;
    logic wr1;
    logic commit;
    logic load;
  } twdc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    kind_e      kind;
    logic [3:0] op;
    logic       hit;
    logic       dirty;
    logic       quad;
    logic       clr_done;
    logic       cnt7;
    logic       cnt8;
  } twdc_stat_t;

endpackage
`default_nettype wire

>>> design/twdc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdc_if
// Request and response channels of the data cache (valid/ready).
// ----------------------------------------------------------------------------
interface twdc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  access_size;
  logic [15:0] address;
  logic [63:0] write_lo;
  logic [63:0] write_hi;
  logic [3:0]  cache_op;
  logic [31:0] tag_lo_in;

  modport source (output valid, req_type, access_size, address, write_lo, write_hi,
                  cache_op, tag_lo_in, input ready);
  modport sink (input valid, req_type, access_size, address, write_lo, write_hi,
                cache_op, tag_lo_in, output ready);
endinterface

interface twdc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_lo;
  logic [63:0] read_hi;
  logic [31:0] tag_lo_out;
  logic        tag_lo_written;
  logic        was_hit;
  logic        wrote_back;

  modport source (output valid, read_lo, read_hi, tag_lo_out, tag_lo_written, was_hit,
                  wrote_back, input ready);
  modport sink (input valid, read_lo, read_hi, tag_lo_out, tag_lo_written, was_hit,
                wrote_back, output ready);
endinterface
`default_nettype wire

>>> design/two_way_data_cache_lrf.sv
// A hit read or write passes lookup, word access and tag commit; a 16-byte write
// writes a second word. A miss adds a line fill, after a write-back if the victim
// is dirty. A maintenance op may add a write-back and a line drop.
// Throughput: one item at a time; the next item is taken the cycle after the
// result is loaded. Reset: asynchronous, active low; a clearing pass zeroes all
// memories before the first item.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_way_data_cache_lrf
// Two-way set-associative write-back data cache over a backing memory.
// ----------------------------------------------------------------------------
module two_way_data_cache_lrf
  import twdc_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  twdc_req_if.sink    req_i,
  twdc_rsp_if.source  rsp_o
);

  twdc_cmd_t  cmd;
  twdc_stat_t stat;

  twdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  twdc_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_type_i       (req_i.req_type),
    .access_size_i    (req_i.access_size),
    .address_i        (req_i.address),
    .write_lo_i       (req_i.write_lo),
    .write_hi_i       (req_i.write_hi),
    .cache_op_i       (req_i.cache_op),
    .tag_lo_in_i      (req_i.tag_lo_in),
    .read_lo_o        (rsp_o.read_lo),
    .read_hi_o        (rsp_o.read_hi),
    .tag_lo_out_o     (rsp_o.tag_lo_out),
    .tag_lo_written_o (rsp_o.tag_lo_written),
    .was_hit_o        (rsp_o.was_hit),
    .wrote_back_o     (rsp_o.wrote_back)
  );

endmodule
`default_nettype wire

>>> design/twdc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twdc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> design/twdc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdc_ctrl
// Sequencer of the cache: clearing pass, lookup, write-back, fill, line drop,
// word access, tag commit and result hand-off.
// ----------------------------------------------------------------------------
module twdc_ctrl
  import twdc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire twdc_stat_t stat_i,
  output twdc_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_WB, S_FILL, S_DROP,
    S_RD0, S_RD1, S_RD2, S_WR0, S_WR1, S_COMMIT, S_DONE
  } state_e;

  state_e state_q;
  logic   do_fill_q, do_drop_q, do_rd_q, do_wr_q, do_wr2_q;
  logic   out_valid_q;
  logic   p_wb, p_fill, p_drop, p_rd, p_wr;
  logic   load;

  // choose the next stage from the remaining work
  function automatic state_e pick(input logic wb, input logic fill, input logic drop,
                                  input logic rd);
    state_e s;
    s = S_COMMIT;
    if (rd)   s = S_RD0;
    if (drop) s = S_DROP;
    if (fill) s = S_FILL;
    if (wb)   s = S_WB;
    return s;
  endfunction

  // work plan of the item from the lookup result
  always_comb begin
    p_wb = 1'b0; p_fill = 1'b0; p_drop = 1'b0; p_rd = 1'b0; p_wr = 1'b0;
    case (stat_i.kind)
      K_READ, K_WRITE: begin
        p_fill = !stat_i.hit;
        p_wb   = !stat_i.hit && stat_i.dirty;
        p_rd   = 1'b1;
        p_wr   = (stat_i.kind == K_WRITE);
      end
      K_HITOP: begin
        p_wb   = stat_i.hit && (stat_i.op != OP_DHIN) && stat_i.dirty;
        p_drop = stat_i.hit && (stat_i.op != OP_DHWOIN);
      end
      K_INDEX: begin
        case (stat_i.op)
          OP_DXIN:   p_drop = 1'b1;
          OP_DXLDT:  p_rd = 1'b1;
          OP_DXLTG:  p_wb = stat_i.dirty;
          OP_DXSDT: begin
            p_rd = 1'b1;
            p_wr = 1'b1;
          end
          OP_DXWBIN: begin
            p_wb   = stat_i.dirty;
            p_drop = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign load        = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // decode commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.clear_run = (state_q == S_CLEAR);
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.lookup    = (state_q == S_LOOKUP);
    cmd_o.wb        = (state_q == S_WB);
    cmd_o.fill      = (state_q == S_FILL);
    cmd_o.drop      = (state_q == S_DROP);
    cmd_o.rd0       = (state_q == S_RD0);
    cmd_o.rd1       = (state_q == S_RD1);
    cmd_o.rd2       = (state_q == S_RD2);
    cmd_o.wr0       = (state_q == S_WR0);
    cmd_o.wr1       = (state_q == S_WR1);
    cmd_o.commit    = (state_q == S_COMMIT);
    cmd_o.load      = load;
    cmd_o.cnt_run   = ((state_q == S_WB || state_q == S_FILL) && !stat_i.cnt8) ||
                      ((state_q == S_DROP) && !stat_i.cnt7);
  end

  // state, plan and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      do_fill_q   <= 1'b0;
      do_drop_q   <= 1'b0;
      do_rd_q     <= 1'b0;
      do_wr_q     <= 1'b0;
      do_wr2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: if (stat_i.clr_done) state_q <= S_IDLE;
        S_IDLE:  if (in_valid_i) state_q <= S_LOOKUP;
        S_LOOKUP: begin
          do_fill_q <= p_fill;
          do_drop_q <= p_drop;
          do_rd_q   <= p_rd;
          do_wr_q   <= p_wr;
          do_wr2_q  <= p_wr && stat_i.quad && (stat_i.kind == K_WRITE);
          state_q   <= pick(p_wb, p_fill, p_drop, p_rd);
        end
        S_WB:   if (stat_i.cnt8) state_q <= pick(1'b0, do_fill_q, do_drop_q, do_rd_q);
        S_FILL: if (stat_i.cnt8) state_q <= pick(1'b0, 1'b0, do_drop_q, do_rd_q);
        S_DROP: if (stat_i.cnt7) state_q <= pick(1'b0, 1'b0, 1'b0, do_rd_q);
        S_RD0:  state_q <= S_RD1;
        S_RD1:  state_q <= S_RD2;
        S_RD2:  state_q <= do_wr_q ? S_WR0 : S_COMMIT;
        S_WR0:  state_q <= do_wr2_q ? S_WR1 : S_COMMIT;
        S_WR1:  state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_DONE;
        S_DONE: begin
          if (load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/twdc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdc_dp
// Datapath of the cache: request registers, tag/line/backing memories,
// sweep counters, byte-lane merge and result registers.
// ----------------------------------------------------------------------------
module twdc_dp
  import twdc_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire twdc_cmd_t   cmd_i,
  output twdc_stat_t       stat_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [2:0]  access_size_i,
  input  wire logic [15:0] address_i,
  input  wire logic [63:0] write_lo_i,
  input  wire logic [63:0] write_hi_i,
  input  wire logic [3:0]  cache_op_i,
  input  wire logic [31:0] tag_lo_in_i,
  output logic      [63:0] read_lo_o,
  output logic      [63:0] read_hi_o,
  output logic      [31:0] tag_lo_out_o,
  output logic             tag_lo_written_o,
  output logic             was_hit_o,
  output logic             wrote_back_o
);

  localparam int unsigned MEM_AW    = ADDR_BITS - 3;
  localparam int unsigned MEM_DEPTH = 1 << MEM_AW;
  localparam int unsigned LINE_AW   = $clog2(LINE_DEPTH);
  localparam int unsigned SET_AW    = $clog2(NUM_SETS);

  // captured request
  logic [1:0]           req_q;
  logic [2:0]           lsz_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [63:0]          wlo_q, whi_q;
  logic [3:0]           op_q;
  logic [31:0]          tlo_q;
  logic [31:0]          addr_ext;

  logic [ADDR_BITS-1:0] tags_q [2];
  logic                 way_q, hit_q, wb_done_q;
  logic [63:0]          w0_q, w1_q;
  logic [3:0]           cnt_q;
  logic [MEM_AW-1:0]    clr_cnt_q;
  logic [2:0]           cnt_m1;

  kind_e                kind;
  logic [SET_AW-1:0]    set;
  logic [2:0]           widx;
  logic                 quad_acc, stg;

  // memory ports
  logic [2*ADDR_BITS-1:0] tag_rdata, tag_wdata;
  logic                   tag_we;
  logic [SET_AW-1:0]      tag_waddr;
  logic                   line_we;
  logic [LINE_AW-1:0]     line_waddr, line_raddr;
  logic [63:0]            line_wdata, line_rdata;
  logic                   mem_we;
  logic [MEM_AW-1:0]      mem_waddr, mem_raddr;
  logic [63:0]            mem_wdata, mem_rdata;

  // lookup
  logic [ADDR_BITS-1:0] t0, t1, tsel;
  logic                 m0, m1, hit, way_sel;
  logic [FLAG_BITS-1:0] fill_flags, drop_flags;

  // lanes
  logic [2:0]  eff_lsz, aoff;
  logic [5:0]  sh;
  logic [63:0] lane_mask, wdat, merged, lane_rd;

  assign addr_ext = 32'(address_i);
  assign set      = addr_q[FLAG_BITS-1:LINE_OFF_BITS];
  // a 16-byte access starts on an even word of the line
  assign quad_acc = ((kind == K_READ) || (kind == K_WRITE)) && (lsz_q == LSZ_QUAD);
  assign widx     = {addr_q[LINE_OFF_BITS-1:4], addr_q[3] && !quad_acc};
  assign stg      = (kind == K_INDEX) && (op_q == OP_DXSTG);
  assign cnt_m1   = 3'(cnt_q - 4'd1);

  // classify the captured request
  always_comb begin
    kind = K_NONE;
    if ((req_q == REQ_READ) && (lsz_q <= LSZ_QUAD)) kind = K_READ;
    else if ((req_q == REQ_WRITE) && (lsz_q <= LSZ_QUAD)) kind = K_WRITE;
    else if ((req_q == REQ_CACHE) && (op_q <= OP_DHWOIN)) kind = K_HITOP;
    else if ((req_q == REQ_CACHE) && (op_q <= OP_DXWBIN)) kind = K_INDEX;
  end

  // tag compare and way choice
  always_comb begin
    t0 = tag_rdata[ADDR_BITS-1:0];
    t1 = tag_rdata[2*ADDR_BITS-1:ADDR_BITS];
    m0 = t0[VALID_BIT] && (t0[ADDR_BITS-1:FLAG_BITS] == addr_q[ADDR_BITS-1:FLAG_BITS]);
    m1 = t1[VALID_BIT] && (t1[ADDR_BITS-1:FLAG_BITS] == addr_q[ADDR_BITS-1:FLAG_BITS]);
    hit = m0 || m1;
    case (kind)
      K_INDEX: way_sel = addr_q[0];
      K_HITOP: way_sel = !m0;
      default: way_sel = hit ? !m0 : (t0[LRF_BIT] ^ t1[LRF_BIT]);
    endcase
    tsel = way_sel ? t1 : t0;
  end

  // flag updates for fill and drop
  always_comb begin
    fill_flags            = tags_q[way_q][FLAG_BITS-1:0];
    fill_flags[VALID_BIT] = 1'b1;
    fill_flags[DIRTY_BIT] = 1'b0;
    fill_flags[LRF_BIT]   = !fill_flags[LRF_BIT];
    drop_flags            = '0;
    drop_flags[LRF_BIT]   = tags_q[way_q][LRF_BIT];
  end

  // byte lanes of the addressed word
  always_comb begin
    eff_lsz = (kind == K_INDEX) ? LSZ_WORD : lsz_q;
    case (eff_lsz)
      LSZ_BYTE: begin
        lane_mask = 64'h0000_0000_0000_00FF;
        aoff      = addr_q[2:0];
      end
      LSZ_HALF: begin
        lane_mask = 64'h0000_0000_0000_FFFF;
        aoff      = {addr_q[2:1], 1'b0};
      end
      LSZ_WORD: begin
        lane_mask = 64'h0000_0000_FFFF_FFFF;
        aoff      = {addr_q[2], 2'b00};
      end
      default: begin
        lane_mask = '1;
        aoff      = 3'd0;
      end
    endcase
    sh      = {aoff, 3'b000};
    wdat    = (kind == K_INDEX) ? 64'(tlo_q) : wlo_q;
    merged  = (w0_q & ~(lane_mask << sh)) | ((wdat & lane_mask) << sh);
    lane_rd = (w0_q >> sh) & lane_mask;
  end

  // status to the controller
  always_comb begin
    stat_o          = '0;
    stat_o.kind     = kind;
    stat_o.op       = op_q;
    stat_o.hit      = hit;
    stat_o.dirty    = tsel[DIRTY_BIT] && tsel[VALID_BIT];
    stat_o.quad     = (lsz_q == LSZ_QUAD);
    stat_o.clr_done = &clr_cnt_q;
    stat_o.cnt7     = (cnt_q == DROP_LAST);
    stat_o.cnt8     = (cnt_q == SWEEP_LAST);
  end

  // line memory port selection
  always_comb begin
    line_we    = 1'b0;
    line_waddr = {set, way_q, widx};
    line_wdata = '0;
    line_raddr = {set, way_q, widx};
    if (cmd_i.clear_run) begin
      line_we    = 1'b1;
      line_waddr = clr_cnt_q[LINE_AW-1:0];
    end
    if (cmd_i.fill) begin
      line_we    = (cnt_q != 4'd0);
      line_waddr = {set, way_q, cnt_m1};
      line_wdata = mem_rdata;
    end
    if (cmd_i.drop) begin
      line_we    = 1'b1;
      line_waddr = {set, way_q, cnt_q[2:0]};
    end
    if (cmd_i.wr0) begin
      line_we    = 1'b1;
      line_wdata = merged;
    end
    if (cmd_i.wr1) begin
      line_we    = 1'b1;
      line_waddr = {set, way_q, 3'(widx + 3'd1)};
      line_wdata = whi_q;
    end
    if (cmd_i.wb) line_raddr = {set, way_q, cnt_q[2:0]};
    if (cmd_i.rd1) line_raddr = {set, way_q, 3'(widx + 3'd1)};
  end

  // backing memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {tags_q[way_q][ADDR_BITS-1:FLAG_BITS], set, cnt_m1};
    mem_wdata = line_rdata;
    mem_raddr = {addr_q[ADDR_BITS-1:LINE_OFF_BITS], cnt_q[2:0]};
    if (cmd_i.clear_run) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end
    if (cmd_i.wb) mem_we = (cnt_q != 4'd0);
  end

  // tag memory write: clearing pass or commit of the set
  always_comb begin
    tag_we    = cmd_i.clear_run || cmd_i.commit;
    tag_waddr = cmd_i.clear_run ? clr_cnt_q[SET_AW-1:0] : set;
    tag_wdata = cmd_i.clear_run ? '0 : {tags_q[1], tags_q[0]};
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      clr_cnt_q <= '0;
      wb_done_q <= 1'b0;
    end else begin
      cnt_q <= cmd_i.cnt_run ? 4'(cnt_q + 4'd1) : 4'd0;
      if (cmd_i.clear_run) clr_cnt_q <= MEM_AW'(clr_cnt_q + 1'b1);
      if (cmd_i.lookup) wb_done_q <= 1'b0;
      if (cmd_i.wb && (cnt_q == SWEEP_LAST)) wb_done_q <= 1'b1;
    end
  end

  // request capture, tag working copy, word and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      lsz_q  <= access_size_i;
      addr_q <= addr_ext[ADDR_BITS-1:0];
      wlo_q  <= write_lo_i;
      whi_q  <= write_hi_i;
      op_q   <= cache_op_i;
      tlo_q  <= tag_lo_in_i;
    end
    if (cmd_i.lookup) begin
      // a tag store replaces the flags of the indexed way
      tags_q[0] <= (stg && !way_sel) ?
                   {t0[ADDR_BITS-1:FLAG_BITS], tlo_q[FLAG_BITS-1:0]} : t0;
      tags_q[1] <= (stg && way_sel) ?
                   {t1[ADDR_BITS-1:FLAG_BITS], tlo_q[FLAG_BITS-1:0]} : t1;
      way_q     <= way_sel;
      hit_q     <= hit;
    end
    if (cmd_i.wb && (cnt_q == SWEEP_LAST)) tags_q[way_q][DIRTY_BIT] <= 1'b0;
    if (cmd_i.fill && (cnt_q == SWEEP_LAST)) begin
      tags_q[way_q] <= {addr_q[ADDR_BITS-1:FLAG_BITS], fill_flags};
    end
    if (cmd_i.drop) tags_q[way_q] <= {{(ADDR_BITS-FLAG_BITS){1'b0}}, drop_flags};
    if (cmd_i.wr0 && (kind == K_WRITE)) tags_q[way_q][DIRTY_BIT] <= 1'b1;
    if (cmd_i.rd1) w0_q <= line_rdata;
    if (cmd_i.rd2) w1_q <= line_rdata;
    if (cmd_i.load) begin
      read_lo_o        <= (kind == K_READ) ? lane_rd : 64'd0;
      read_hi_o        <= ((kind == K_READ) && (lsz_q == LSZ_QUAD)) ? w1_q : 64'd0;
      tag_lo_written_o <= (kind == K_INDEX) && (op_q == OP_DXLDT || op_q == OP_DXLTG);
      was_hit_o        <= (kind == K_READ || kind == K_WRITE || kind == K_HITOP) && hit_q;
      wrote_back_o     <= wb_done_q;
      if ((kind == K_INDEX) && (op_q == OP_DXLDT)) begin
        tag_lo_out_o <= lane_rd[31:0];
      end else if ((kind == K_INDEX) && (op_q == OP_DXLTG)) begin
        tag_lo_out_o <= 32'(tags_q[way_q][FLAG_BITS-1:0]);
      end else begin
        tag_lo_out_o <= '0;
      end
    end
  end

  twdc_ram #(.WIDTH(2 * ADDR_BITS), .DEPTH(NUM_SETS)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .raddr_i (address_i[FLAG_BITS-1:LINE_OFF_BITS]),
    .rdata_o (tag_rdata)
  );

  twdc_ram #(.WIDTH(64), .DEPTH(LINE_DEPTH)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  twdc_ram #(.WIDTH(64), .DEPTH(MEM_DEPTH)) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

>>> design/twdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twdc_checker
// Port-level checks of the data cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_way_data_cache_lrf_assert.svh"

module twdc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] read_lo_i,
  input wire logic [63:0] read_hi_i,
  input wire logic        tag_lo_written_i,
  input wire logic        was_hit_i
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // count items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= 2'(pend_q + {1'b0, in_acc} - {1'b0, out_acc});
    end
  end

  `TWDC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `TWDC_ASSERT_NOW(a_no_phantom, clk_i, rst_ni, out_valid_i, pend_q != 2'd0)
  `TWDC_ASSERT_NOW(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q != 2'd3)
  `TWDC_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_acc, !in_ready_i)
  `TWDC_ASSERT_NOW(a_tag_load_clean, clk_i, rst_ni, out_valid_i && tag_lo_written_i,
                   !was_hit_i && read_lo_i == 64'd0 && read_hi_i == 64'd0)

endmodule

bind two_way_data_cache_lrf twdc_checker u_twdc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .read_lo_i        (rsp_o.read_lo),
  .read_hi_i        (rsp_o.read_hi),
  .tag_lo_written_i (rsp_o.tag_lo_written),
  .was_hit_i        (rsp_o.was_hit)
);
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives reads, writes and maintenance operations into the two-way data cache
// and checks every response against a cycle-free predictor of tags, lines and
// backing memory, under several idling and stalling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import twdc_pkg::*;

  localparam int unsigned ABITS     = 16;
  localparam int unsigned MEMW      = 1 << (ABITS - 3);
  localparam logic [3:0]  OP_NONE   = 4'd9;
  localparam logic [1:0]  REQ_SPARE = 2'd3;
  localparam logic [2:0]  LSZ_DBL   = 3'd3;
  localparam logic [11:0] F_DIRTY   = 12'h040;
  localparam logic [11:0] F_VALID   = 12'h020;
  localparam logic [11:0] F_LRF     = 12'h010;
  localparam int          IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] rlo;
    logic [63:0] rhi;
    logic [31:0] tlo;
    logic        twr;
    logic        hit;
    logic        wb;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  twdc_req_if req_ch();
  twdc_rsp_if rsp_ch();

  two_way_data_cache_lrf #(.ADDR_BITS(ABITS)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predicted cache contents
  logic [15:0] tags [128];
  logic [63:0] lines [1024];
  logic [63:0] bmem [MEMW];

  resp_t expected_q[$];
  int    mismatches = 0;
  int    checked = 0;
  int    idle_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    n_hits = 0, n_wbs = 0;

  function automatic int flush_line(int slot, int set);
    logic [15:0] t;
    int base;
    t = tags[slot];
    if ((t[11:0] & (F_DIRTY | F_VALID)) != (F_DIRTY | F_VALID)) return 0;
    base = ({t[15:12], 12'h000} | (set << 6)) >> 3;
    for (int i = 0; i < 8; i++) bmem[(base + i) % MEMW] = lines[slot * 8 + i];
    tags[slot] = t & ~{4'h0, F_DIRTY};
    return 1;
  endfunction

  function automatic void fill_line(int slot, logic [15:0] addr);
    int base;
    base = {addr[15:6], 6'd0} >> 3;
    tags[slot] = ({4'h0, tags[slot][11:0]} | {addr[15:12], 12'h000} | F_VALID)
                 & ~{4'h0, F_DIRTY};
    for (int i = 0; i < 8; i++) lines[slot * 8 + i] = bmem[(base + i) % MEMW];
  endfunction

  function automatic void drop_line(int slot);
    tags[slot] = tags[slot] & {4'h0, F_LRF};
    for (int i = 0; i < 8; i++) lines[slot * 8 + i] = '0;
  endfunction

  function automatic int find_way(int set, logic [15:0] addr);
    for (int w = 0; w < 2; w++)
      if ((tags[set * 2 + w][11:0] & F_VALID) != 0 && tags[set * 2 + w][15:12] == addr[15:12])
        return w;
    return -1;
  endfunction

  // Work out the response of one request and update the predicted state
  function automatic resp_t cache_access(logic [1:0] rt, logic [2:0] lsz, logic [15:0] addr,
                                         logic [63:0] wlo, logic [63:0] whi,
                                         logic [3:0] op, logic [31:0] tli);
    resp_t r;
    int set, way, slot, bytes, off, sh, idx;
    logic [63:0] m;
    r = '0;
    set = addr[11:6];
    if (rt <= REQ_WRITE && lsz <= LSZ_QUAD) begin
      bytes = 1 << lsz;
      off = (addr & ~(bytes - 1)) & 6'h3f;
      way = find_way(set, addr);
      if (way >= 0) r.hit = 1'b1;
      else begin
        way = ((tags[set * 2] ^ tags[set * 2 + 1]) & F_LRF) != 0;
        slot = set * 2 + way;
        r.wb = 1'(flush_line(slot, set));
        fill_line(slot, addr);
        tags[slot] = tags[slot] ^ {4'h0, F_LRF};
      end
      slot = set * 2 + way;
      idx = slot * 8 + (off >> 3);
      sh = (off & 7) * 8;
      m = (bytes >= 8) ? '1 : ((64'd1 << (bytes * 8)) - 1);
      if (rt == REQ_WRITE) begin
        tags[slot] = tags[slot] | F_DIRTY;
        if (bytes == 16) begin
          lines[idx] = wlo;
          lines[idx + 1] = whi;
        end else if (bytes == 8) lines[idx] = wlo;
        else lines[idx] = (lines[idx] & ~(m << sh)) | ((wlo & m) << sh);
      end else begin
        if (bytes == 16) begin
          r.rlo = lines[idx];
          r.rhi = lines[idx + 1];
        end else if (bytes == 8) r.rlo = lines[idx];
        else r.rlo = (lines[idx] >> sh) & m;
      end
    end else if (rt == REQ_CACHE && op <= OP_DHWOIN) begin
      way = find_way(set, addr);
      if (way >= 0) begin
        r.hit = 1'b1;
        slot = set * 2 + way;
        if (op != OP_DHIN) r.wb = 1'(flush_line(slot, set));
        if (op != OP_DHWOIN) drop_line(slot);
      end
    end else if (rt == REQ_CACHE && op <= OP_DXWBIN) begin
      slot = set * 2 + addr[0];
      idx = slot * 8 + addr[5:3];
      sh = addr[2] * 32;
      case (op)
        OP_DXIN: drop_line(slot);
        OP_DXLDT: begin
          r.tlo = 32'(lines[idx] >> sh);
          r.twr = 1'b1;
        end
        OP_DXLTG: begin
          r.wb = 1'(flush_line(slot, set));
          r.tlo = 32'(tags[slot][11:0]);
          r.twr = 1'b1;
        end
        OP_DXSDT: lines[idx] = (lines[idx] & ~(64'hffff_ffff << sh)) | ({32'd0, tli} << sh);
        OP_DXSTG: tags[slot] = {tags[slot][15:12], tli[11:0]};
        default: begin
          r.wb = 1'(flush_line(slot, set));
          drop_line(slot);
        end
      endcase
    end
    return r;
  endfunction

  // Send one request, predicting its response on acceptance
  task automatic send_request(logic [1:0] rt, logic [2:0] lsz, logic [15:0] addr,
                              logic [63:0] wlo, logic [63:0] whi,
                              logic [3:0] op, logic [31:0] tli);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.access_size <= lsz;
    req_ch.address <= addr;
    req_ch.write_lo <= wlo;
    req_ch.write_hi <= whi;
    req_ch.cache_op <= op;
    req_ch.tag_lo_in <= tli;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_q.push_back(cache_access(rt, lsz, addr, wlo, whi, op, tli));
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Stall the response channel at random
  always @(negedge clk_i)
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Compare each response with the oldest prediction
  always @(posedge clk_i) begin
    resp_t got, exp_r;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.read_lo, rsp_ch.read_hi, rsp_ch.tag_lo_out, rsp_ch.tag_lo_written,
             rsp_ch.was_hit, rsp_ch.wrote_back};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        n_hits += got.hit;
        n_wbs += got.wb;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: rlo %h/%h rhi %h/%h tlo %h/%h twr %b/%b hit %b/%b wb %b/%b",
                     exp_r.rlo, got.rlo, exp_r.rhi, got.rhi, exp_r.tlo, got.tlo,
                     exp_r.twr, got.twr, exp_r.hit, got.hit, exp_r.wb, got.wb);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item; the clearing pass counts too
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT + MEMW) begin
      $display("Watchdog expired");
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] a;
    a = 16'h1040;
    send_request(REQ_READ, LSZ_BYTE, 16'h0000, '0, '0, OP_NONE, '0);
    for (int s = 0; s <= 4; s++)
      send_request(REQ_WRITE, s[2:0], 16'(a + (1 << s)), '1, 64'hA5A5_5A5A_0F0F_F0F0,
                   OP_NONE, '0);
    for (int s = 0; s <= 4; s++)
      send_request(REQ_READ, s[2:0], a, '0, '0, OP_NONE, '0);
    // Evict a dirty line by touching two more tags in the same set
    send_request(REQ_READ, LSZ_DBL, 16'h2040, '0, '0, OP_NONE, '0);
    send_request(REQ_WRITE, LSZ_DBL, 16'hF040, '1, '1, OP_NONE, '0);
    send_request(REQ_READ, LSZ_QUAD, 16'h1050, '0, '0, OP_NONE, '0);
    for (int op = 0; op <= 15; op++)
      send_request(REQ_CACHE, LSZ_BYTE, 16'(16'hF041 + op * 4), '0, '0, op[3:0],
                   32'hFFFF_FFFF);
    send_request(REQ_SPARE, LSZ_BYTE, 16'hFFFF, '1, '1, OP_DXIN, '1);
    send_request(REQ_READ, 3'd7, 16'hFFFF, '1, '1, OP_NONE, '1);
  endtask

  task automatic test_random(int count);
    logic [1:0] rt;
    logic [2:0] lsz;
    logic [3:0] op;
    logic [15:0] addr;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      // Mostly well-formed accesses on a few tags, so sets fill and evict
      rt = (sel < 40) ? REQ_READ : (sel < 75) ? REQ_WRITE : (sel < 97) ? REQ_CACHE : REQ_SPARE;
      lsz = 3'(($urandom_range(19) == 0) ? $urandom_range(5, 7) : $urandom_range(4));
      op = 4'(($urandom_range(19) == 0) ? $urandom_range(9, 15) : $urandom_range(8));
      addr = 16'($urandom());
      if ($urandom_range(3) != 0) addr[15:12] = 4'($urandom_range(3));
      if ($urandom_range(1)) addr[11:6] = 6'($urandom_range(3));
      send_request(rt, lsz, addr, rand64(), rand64(), op, $urandom());
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_READ;
    req_ch.access_size = LSZ_BYTE;
    req_ch.address = '0;
    req_ch.write_lo = '0;
    req_ch.write_hi = '0;
    req_ch.cache_op = OP_NONE;
    req_ch.tag_lo_in = '0;
    rsp_ch.ready = 1'b1;
    for (int i = 0; i < 128; i++) tags[i] = '0;
    for (int i = 0; i < 1024; i++) lines[i] = '0;
    for (int i = 0; i < MEMW; i++) bmem[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(450);
    send_idle_pct = 59;
    test_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 59;
    test_random(450);
    send_idle_pct = 10;
    recv_stall_pct = 10;
    test_random(450);
    drain();
    $display("Checked %0d responses: %0d hits, %0d write-backs, all request kinds and ops",
             checked, n_hits, n_wbs);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> sim.f
+incdir+design
design/twdc_pkg.sv
design/twdc_if.sv
design/twdc_ram.sv
design/twdc_ctrl.sv
design/twdc_dp.sv
design/two_way_data_cache_lrf.sv
design/twdc_checker.sv
sim/testbench.sv
